/* hdl/mrs_pkg.sv */
// Shared types, constants and SHA-256 helpers for the Merkle root unit.
`default_nettype none
package mrs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_WRITE,
        ST_OUT
    } t_state;

    localparam logic MODE_LEAF = 1'b0;
    localparam logic MODE_SEED = 1'b1;

    localparam logic REG_STYLE = 1'b0;
    localparam logic REG_TEN   = 1'b1;

    localparam logic [3:0] SEED_LEN_NONE = 4'd0;
    localparam logic [3:0] SEED_LEN_FOUR = 4'd4;
    localparam logic [3:0] SEED_LEN_TEN  = 4'd10;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Word j of the padded tail that follows the node data: seed bytes,
    // then the 0x80 marker, then zeros.
    function automatic logic [31:0] tail_word(input logic [4:0] j,
                                              input logic [3:0] slen,
                                              input logic [127:0] sb);
        logic [31:0]  w;
        logic [6:0]   x;
        logic [127:0] sh;
        w = '0;
        for (int b = 0; b < 4; b++) begin
            x  = {j, 2'(b)};
            sh = sb << {x, 3'b000};
            if (x < {3'b000, slen}) begin
                w[31 - 8*b -: 8] = sh[127:120];
            end else if (x == {3'b000, slen}) begin
                w[31 - 8*b -: 8] = 8'h80;
            end
        end
        return w;
    endfunction

endpackage
`default_nettype wire

/* hdl/mrs_if.sv */
// Handshake channels for input beats and root word beats.
`default_nettype none
interface mrs_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] data_word;
    logic [1:0]  word_index;
    logic        last_leaf;
    modport source (output valid, mode, data_word, word_index, last_leaf, input ready);
    modport sink (input valid, mode, data_word, word_index, last_leaf, output ready);
endinterface

interface mrs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] root_word;
    logic [1:0]  out_index;
    logic        final_word;
    logic        overflow;
    modport source (output valid, root_word, out_index, final_word, overflow, input ready);
    modport sink (input valid, root_word, out_index, final_word, overflow, output ready);
endinterface
`default_nettype wire

/* hdl/merkle_root_sha256_with_seed_unit.sv */
// Flow: input beats are stored as accepted; the last leaf beat starts the reduction. Each SHA-256
// block is loaded (schedule fill), run through 64 rounds and added; a stored node is then written
// back as four words. A lone node hashes in one block and a pair in two; then 4 root beats.
// Throughput: set by the single shared SHA-256 round unit, roughly two compressions per
// leaf over the tree; input is not taken while the tree is reduced or the root is sent.
// Reset: sync, active low; clears count, overflow and seed, style bits to 1; leaf memory kept.
`default_nettype none
module merkle_root_sha256_with_seed_unit
    import mrs_pkg::*;
#(
    parameter int MAX_LEAVES = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mrs_in_if.sink      i_in,
    mrs_out_if.source   o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW    = $clog2(MAX_LEAVES + 1);
    localparam int AW    = $clog2(MAX_LEAVES) + 2;
    localparam int DEPTH = MAX_LEAVES * 4;

    t_state r_state, n_state;

    logic [63:0]   leaf_mem [DEPTH];
    logic [63:0]   r_q;
    logic [CW-1:0] r_count;
    logic          r_drop;
    logic [63:0]   r_seed [2];
    logic          r_style;
    logic          r_ten;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic          r_final;
    logic          r_rehash;
    logic          r_blk;
    logic [4:0]    r_ld;
    logic [5:0]    r_rnd;
    logic [1:0]    r_k;
    logic [31:0]   r_w [16];
    logic [31:0]   r_v [8];
    logic [31:0]   r_h [8];

    logic          in_acc, out_acc, cfg_wr;
    logic          room, store_leaf;
    logic [CW-1:0] cnt_next;
    logic          two;
    logic [3:0]    slen;
    logic [4:0]    dwords;
    logic [6:0]    msg_len;
    logic          blk2;
    logic [CW:0]   pair;
    logic [CW:0]   base;
    logic [5:0]    rp;
    logic [4:0]    p;
    logic [31:0]   ld_word;
    logic [31:0]   w_new, t1, t2;
    logic [CW-1:0] wnode;
    logic [CW-1:0] m_half;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [63:0]   mem_wd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_TEN) ? {31'b0, r_ten} : {31'b0, r_style};

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = (r_state == ST_OUT);
    assign out_acc     = o_out.valid && o_out.ready;

    assign o_out.root_word  = {r_h[{r_k, 1'b0}], r_h[{r_k, 1'b1}]};
    assign o_out.out_index  = r_k;
    assign o_out.final_word = (r_k == 2'd3);
    assign o_out.overflow   = r_drop;

    assign room       = (r_count < CW'(MAX_LEAVES));
    assign store_leaf = in_acc && (i_in.mode == MODE_LEAF) && room;
    assign cnt_next   = r_count + CW'(store_leaf && (i_in.word_index == 2'd3 || i_in.last_leaf));

    // Shape of the message for the current node hash.
    assign pair = {r_i, 1'b0};
    always_comb begin
        if (r_rehash) begin
            two = 1'b0;
        end else if (r_final) begin
            two = (r_n == CW'(2));
        end else begin
            two = ((pair + (CW+1)'(1)) < {1'b0, r_n});
        end
        if (r_final && !r_rehash) begin
            slen = (r_style && r_ten) ? SEED_LEN_TEN : SEED_LEN_FOUR;
        end else begin
            slen = SEED_LEN_NONE;
        end
    end
    assign dwords  = two ? 5'd16 : 5'd8;
    assign msg_len = {dwords, 2'b00} + {3'b000, slen};
    assign blk2    = (msg_len > 7'd55);
    assign base    = r_rehash ? '0 : pair;

    // Memory read runs one word ahead of the schedule fill.
    assign rp = {r_blk, 5'b00000} + {1'b0, r_ld};
    assign p  = {r_blk, 4'(r_ld - 5'd1)};
    always_comb begin
        if (p < dwords) begin
            ld_word = p[0] ? r_q[31:0] : r_q[63:32];
        end else if (p == (blk2 ? 5'd31 : 5'd15)) begin
            ld_word = {22'b0, msg_len, 3'b000};
        end else begin
            ld_word = tail_word(p - dwords, slen, {r_seed[0], r_seed[1]});
        end
    end

    assign w_new = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
    assign t1    = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                   + K_TABLE[r_rnd] + r_w[0];
    assign t2    = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign wnode  = r_final ? '0 : r_i;
    assign m_half = CW'(({1'b0, r_n} + (CW+1)'(1)) >> 1);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = AW'({r_count, i_in.word_index});
        mem_wd = i_in.data_word;
        mem_ra = AW'({base, 2'b00} + (CW+2)'(rp[5:1]));
        if (r_state == ST_WRITE) begin
            mem_we = 1'b1;
            mem_wa = AW'({wnode, r_k});
            mem_wd = {r_h[{r_k, 1'b0}], r_h[{r_k, 1'b1}]};
        end else if (store_leaf) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            leaf_mem[mem_wa] <= mem_wd;
        end
        r_q <= leaf_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in.mode == MODE_LEAF && i_in.last_leaf) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (r_ld == 5'd16) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_rnd == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!r_blk && blk2) begin
                    n_state = ST_LOAD;
                end else if (r_final && (r_style || r_rehash)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (r_k == 2'd3) begin
                    n_state = ST_LOAD;
                end
            end
            ST_OUT: begin
                if (out_acc && r_k == 2'd3) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_seed   <= '{default: '0};
            r_style  <= 1'b1;
            r_ten    <= 1'b1;
            r_n      <= '0;
            r_i      <= '0;
            r_final  <= 1'b0;
            r_rehash <= 1'b0;
            r_blk    <= 1'b0;
            r_ld     <= '0;
            r_rnd    <= '0;
            r_k      <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_STYLE) begin
                    r_style <= pwdata[0];
                end else begin
                    r_ten <= pwdata[0];
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in.mode == MODE_SEED) begin
                            if (!i_in.word_index[1]) begin
                                r_seed[i_in.word_index[0]] <= i_in.data_word;
                            end
                        end else begin
                            r_count <= cnt_next;
                            if (!room) begin
                                r_drop <= 1'b1;
                            end
                            if (i_in.last_leaf) begin
                                r_n      <= cnt_next;
                                r_i      <= '0;
                                r_final  <= (cnt_next <= CW'(2));
                                r_rehash <= 1'b0;
                                r_blk    <= 1'b0;
                                r_ld     <= '0;
                            end
                        end
                    end
                end
                ST_LOAD: begin
                    r_ld  <= r_ld + 5'd1;
                    r_rnd <= '0;
                end
                ST_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                end
                ST_ADD: begin
                    r_ld <= '0;
                    r_k  <= '0;
                    if (!r_blk && blk2) begin
                        r_blk <= 1'b1;
                    end
                end
                ST_WRITE: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_blk <= 1'b0;
                        r_ld  <= '0;
                        if (r_final) begin
                            r_rehash <= 1'b1;
                        end else if (r_i + CW'(1) == m_half) begin
                            r_n     <= m_half;
                            r_i     <= '0;
                            r_final <= (m_half <= CW'(2));
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            r_count <= '0;
                            r_drop  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Shared round datapath: schedule window, working variables, chaining state
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_h <= IV_TABLE;
            end
            ST_LOAD: begin
                if (r_ld != 5'd0) begin
                    for (int k = 0; k < 15; k++) begin
                        r_w[k] <= r_w[k+1];
                    end
                    r_w[15] <= ld_word;
                end
                if (r_ld == 5'd16) begin
                    r_v <= r_h;
                end
            end
            ST_ROUND: begin
                for (int k = 0; k < 15; k++) begin
                    r_w[k] <= r_w[k+1];
                end
                r_w[15] <= w_new;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            ST_ADD: begin
                for (int k = 0; k < 8; k++) begin
                    r_h[k] <= r_h[k] + r_v[k];
                end
            end
            ST_WRITE: begin
                if (r_k == 2'd3) begin
                    r_h <= IV_TABLE;
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input taken while root beats pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.final_word) |=> (r_count == '0 && !r_drop))
        else $error("leaf count not cleared after root");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEAVES))
        else $error("leaf count beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode == MODE_LEAF && i_in.last_leaf) |=> (r_state == ST_LOAD))
        else $error("reduction did not start");

endmodule
`default_nettype wire

/* tb/merkle_root_sha256_with_seed_unit_tb.sv */
// Self-checking testbench for the seeded SHA-256 Merkle root unit.
`default_nettype none
module merkle_root_sha256_with_seed_unit_tb;
    import mrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEAVES  = 1024;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 200;
    localparam int IDLE_WAIT   = 30;
    localparam int PHASE_BEATS = 70;
    localparam logic [2:0] ADDR_STYLE = 3'd0;
    localparam logic [2:0] ADDR_TEN   = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [63:0] data_word;
        logic [1:0]  word_index;
        logic        last_leaf;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] root_word;
        logic [1:0]  out_index;
        logic        final_word;
        logic        overflow;
    } t_root_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mrs_in_if  in_ch ();
    mrs_out_if out_ch ();

    merkle_root_sha256_with_seed_unit #(.MAX_LEAVES(MAX_LEAVES)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_in_beat   pending_beats[$];
    t_root_beat expected_roots[$];
    int         n_errors;
    int         n_roots_seen;
    int         cycles;

    // predictor copy of the block
    logic [63:0] p_mem [4096];
    logic [63:0] p_seed [2];
    int          p_count;
    logic        p_drop;
    logic        cfg_style;
    logic        cfg_ten;

    // stimulus-side view of which leaf slots hold defined data
    bit          g_written [4096];
    int          g_count;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] compress(input logic [255:0] hs, input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++) w[t] = blk[511 - 32*t -: 32];
        for (int t = 16; t < 64; t++) begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        {a, b, c, d, e, f, g, h} = hs;
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + K_TABLE[t] + w[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        return {hs[255:224] + a, hs[223:192] + b, hs[191:160] + c, hs[159:128] + d,
                hs[127:96] + e, hs[95:64] + f, hs[63:32] + g, hs[31:0] + h};
    endfunction

    // msg holds up to 80 bytes, byte 0 in the top bits, zero beyond len
    function automatic logic [255:0] sha_bytes(input logic [639:0] msg, input int len);
        logic [1023:0] pad;
        logic [255:0]  hs;
        pad = '0;
        pad[1023 -: 640] = msg;
        pad[1023 - 8*len -: 8] = 8'h80;
        hs = {IV_TABLE[0], IV_TABLE[1], IV_TABLE[2], IV_TABLE[3],
              IV_TABLE[4], IV_TABLE[5], IV_TABLE[6], IV_TABLE[7]};
        if (len + 9 <= 64) begin
            pad[1023 - 8*56 -: 64] = 64'(len * 8);
            hs = compress(hs, pad[1023:512]);
        end else begin
            pad[63:0] = 64'(len * 8);
            hs = compress(hs, pad[1023:512]);
            hs = compress(hs, pad[511:0]);
        end
        return hs;
    endfunction

    function automatic logic [255:0] node_of(input int i);
        return {p_mem[4*i], p_mem[4*i+1], p_mem[4*i+2], p_mem[4*i+3]};
    endfunction

    function automatic logic [255:0] hash_pair(input int a, input int b, input bit two,
                                               input int slen);
        logic [639:0] msg;
        logic [127:0] sb;
        int           len;
        msg = '0;
        sb  = {p_seed[0], p_seed[1]};
        msg[639 -: 256] = node_of(a);
        len = 32;
        if (two) begin
            msg[383 -: 256] = node_of(b);
            len = 64;
        end
        for (int i = 0; i < slen; i++) msg[639 - 8*(len+i) -: 8] = sb[127 - 8*i -: 8];
        return sha_bytes(msg, len + slen);
    endfunction

    task automatic store_node(input int i, input logic [255:0] dig);
        for (int k = 0; k < 4; k++) p_mem[4*i+k] = dig[255 - 64*k -: 64];
    endtask

    task automatic predict_beat(input t_in_beat bt);
        logic [255:0] dig;
        t_root_beat   rb;
        int           n, m;
        if (bt.mode == MODE_SEED) begin
            if (bt.word_index < 2) p_seed[bt.word_index[0]] = bt.data_word;
            return;
        end
        if (p_count < MAX_LEAVES) begin
            p_mem[4*p_count + bt.word_index] = bt.data_word;
            if (bt.word_index == 2'd3 || bt.last_leaf) p_count++;
        end else begin
            p_drop = 1'b1;
        end
        if (!bt.last_leaf) return;
        n = p_count;
        while (n > 2) begin
            m = (n + 1) / 2;
            for (int i = 0; i < m; i++) store_node(i, hash_pair(2*i, 2*i+1, (2*i+1) < n, 0));
            n = m;
        end
        dig = hash_pair(0, 1, n == 2, (cfg_style && cfg_ten) ? 10 : 4);
        if (!cfg_style) begin
            store_node(0, dig);
            dig = hash_pair(0, 0, 1'b0, 0);
        end
        for (int k = 0; k < 4; k++) begin
            rb.root_word  = dig[255 - 64*k -: 64];
            rb.out_index  = 2'(k);
            rb.final_word = (k == 3);
            rb.overflow   = p_drop;
            expected_roots.insert(expected_roots.size(), rb);
        end
        p_count = 0;
        p_drop  = 1'b0;
    endtask

    // ---------------- stimulus generation ----------------
    task automatic push_beat(input logic m, input logic [63:0] d, input logic [1:0] idx,
                             input logic l);
        t_in_beat bt;
        bt = '{mode: m, data_word: d, word_index: idx, last_leaf: l};
        pending_beats.insert(pending_beats.size(), bt);
        if (m == MODE_LEAF) begin
            if (g_count < MAX_LEAVES) begin
                g_written[4*g_count + idx] = 1'b1;
                if (idx == 2'd3 || l) g_count++;
            end
            if (l) g_count = 0;
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_leaf(input bit is_last);
        int  k, sel, base;
        bit  ok;
        sel  = $urandom_range(0, 9);
        base = 4 * g_count;
        if (is_last && sel == 0 && g_count < MAX_LEAVES) begin
            // early finish: only when the unsent words of the slot are defined
            k  = $urandom_range(0, 2);
            ok = 1;
            for (int j = k + 1; j < 4; j++) if (!g_written[base + j]) ok = 0;
            if (ok) begin
                for (int j = 0; j <= k; j++) push_beat(MODE_LEAF, rand64(), 2'(j), j == k);
                return;
            end
        end
        if (sel < 7) begin
            for (int j = 0; j < 4; j++) push_beat(MODE_LEAF, rand64(), 2'(j), is_last && j == 3);
        end else begin
            // scrambled and repeated lower words before word 3
            for (int j = 0; j < 3; j++) push_beat(MODE_LEAF, rand64(), 2'(j), 1'b0);
            for (int j = $urandom_range(0, 3); j > 0; j--)
                push_beat(MODE_LEAF, rand64(), 2'($urandom_range(0, 2)), 1'b0);
            push_beat(MODE_LEAF, rand64(), 2'd3, is_last);
        end
    endtask

    task automatic push_tree(input int n_leaves);
        for (int s = $urandom_range(0, 2); s > 0; s--)
            push_beat(MODE_SEED, rand64(), 2'($urandom_range(0, 3)), 1'($urandom));
        for (int i = 0; i < n_leaves; i++) begin
            if ($urandom_range(0, 15) == 0)
                push_beat(MODE_SEED, rand64(), 2'($urandom_range(0, 3)), 1'($urandom));
            push_leaf(i == n_leaves - 1);
        end
    endtask

    task automatic random_phase(input int n_items);
        int target;
        target = pending_beats.size() + n_items;
        while (pending_beats.size() < target)
            push_tree(($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8));
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_ch.valid || expected_roots.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_STYLE) cfg_style = val[0];
        else cfg_ten = val[0];
    endtask

    task automatic set_config(input logic style, input logic ten);
        wait_idle();
        apb_write(ADDR_STYLE, {31'b0, style});
        apb_write(ADDR_TEN, {31'b0, ten});
    endtask

    // ---------------- clock, reset, phases ----------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.mode = MODE_LEAF; in_ch.data_word = '0;
        in_ch.word_index = '0; in_ch.last_leaf = 1'b0;
        out_ch.ready = 1'b0;
        n_errors = 0;
        p_count = 0; p_drop = 1'b0; p_seed[0] = '0; p_seed[1] = '0;
        cfg_style = 1'b1; cfg_ten = 1'b1;
        g_count = 0;
        foreach (g_written[i]) g_written[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: seed extremes, ignored seed words, odd leftover, early finish
        push_beat(MODE_SEED, '1, 2'd0, 1'b0);
        push_beat(MODE_SEED, 64'hA5C3_0000_0000_0000, 2'd1, 1'b1);
        push_beat(MODE_SEED, '1, 2'd2, 1'b1);
        push_beat(MODE_SEED, '1, 2'd3, 1'b0);
        for (int j = 0; j < 4; j++) push_beat(MODE_LEAF, '0, 2'(j), j == 3);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 4; j++) push_beat(MODE_LEAF, '1, 2'(j), i == 2 && j == 3);
        push_beat(MODE_LEAF, 64'h8000_0000_0000_0001, 2'd0, 1'b0);
        push_beat(MODE_LEAF, 64'h0123_4567_89AB_CDEF, 2'd1, 1'b1);
        random_phase(PHASE_BEATS);

        set_config(1'b0, 1'b1);
        random_phase(PHASE_BEATS);

        set_config(1'b1, 1'b0);
        random_phase(PHASE_BEATS);

        set_config(1'b0, 1'b0);
        random_phase(PHASE_BEATS);

        set_config(1'b1, 1'b1);
        random_phase(PHASE_BEATS);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end
    initial cycles = 0;

    // ---------------- input driver ----------------
    int  gap_left;
    int  beats_sent;
    bit  idle_on;
    t_in_beat next_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left    <= 0;
            beats_sent  <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_beat('{mode: in_ch.mode, data_word: in_ch.data_word,
                               word_index: in_ch.word_index, last_leaf: in_ch.last_leaf});
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    in_ch.valid <= 1'b0;
                    gap_left    <= gap_left - 1;
                end else if (pending_beats.size() != 0) begin
                    next_beat = pending_beats.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.mode       <= next_beat.mode;
                    in_ch.data_word  <= next_beat.data_word;
                    in_ch.word_index <= next_beat.word_index;
                    in_ch.last_leaf  <= next_beat.last_leaf;
                    beats_sent       <= beats_sent + 1;
                    // alternate stretches with and without gaps
                    idle_on  = ((beats_sent / 40) % 3) != 2;
                    gap_left <= idle_on ? $urandom_range(0, 11) : 0;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- root word monitor ----------------
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    int  stall_draw;
    t_root_beat exp_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
            n_roots_seen <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_roots.size() == 0) begin
                    $error("unexpected root beat: root_word %h", out_ch.root_word);
                    n_errors++;
                end else begin
                    exp_beat = expected_roots.pop_front();
                    if (out_ch.root_word !== exp_beat.root_word) begin
                        $error("root_word: expected %h, got %h",
                               exp_beat.root_word, out_ch.root_word);
                        n_errors++;
                    end
                    if (out_ch.out_index !== exp_beat.out_index) begin
                        $error("out_index: expected %0d, got %0d",
                               exp_beat.out_index, out_ch.out_index);
                        n_errors++;
                    end
                    if (out_ch.final_word !== exp_beat.final_word) begin
                        $error("final_word: expected %0b, got %0b",
                               exp_beat.final_word, out_ch.final_word);
                        n_errors++;
                    end
                    if (out_ch.overflow !== exp_beat.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               exp_beat.overflow, out_ch.overflow);
                        n_errors++;
                    end
                end
                n_roots_seen <= n_roots_seen + 1;
                if (!hold_done && n_roots_seen == 5) begin
                    // long hold-off mid root; sender keeps offering meanwhile
                    hold_done    <= 1'b1;
                    hold_left    <= 600;
                    out_ch.ready <= 1'b0;
                end else begin
                    stall_draw = (((n_roots_seen / 16) % 3) == 1) ? 0 : $urandom_range(0, 11);
                    out_ch.ready <= (stall_draw == 0);
                    stall_left   <= (stall_draw == 0) ? 0 : stall_draw - 1;
                end
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* sim.f */
hdl/mrs_pkg.sv
hdl/mrs_if.sv
hdl/merkle_root_sha256_with_seed_unit.sv
tb/merkle_root_sha256_with_seed_unit_tb.sv
